@@ sv/esu_pkg.sv @@
// shared types and constants for the escape sequence unescaper
`timescale 1ns / 1ps

package esu_pkg;

  localparam int Q_DEPTH   = 4;
  localparam int OUT_DEPTH = 4;

  // characters that the back end has to produce itself
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LOWER_U = 8'h75;

  typedef enum logic [2:0] {
    ERR_OK    = 3'd0,
    ERR_OCTAL = 3'd1,
    ERR_SURR  = 3'd2,
    ERR_HEX   = 3'd3,
    ERR_TRAIL = 3'd4
  } esu_err_t;

  // one character with its classification
  typedef struct packed {
    logic [7:0] ch;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_bslash;
    logic       is_oct;
    logic       is_x;
    logic       is_u;
    logic       is_simple;
    logic [7:0] simple_val;
  } esu_class_t;

  typedef struct packed {
    logic       eos;
    esu_class_t cls;
  } esu_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       valid;
    logic       last;
    esu_err_t   err;
  } esu_res_t;

endpackage

@@ sv/esu_fifo.sv @@
// small register fifo with full and empty flags
`timescale 1ns / 1ps

module esu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ sv/esu_front.sv @@
// front end: classifies incoming characters and queues them for the decoder
`timescale 1ns / 1ps

module esu_front #(
  parameter int Q_DEPTH = esu_pkg::Q_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [7:0]        in_byte,
  input  logic              in_eos,
  output logic              full,
  input  logic              q_pop,
  output logic              q_empty,
  output esu_pkg::esu_item_t q_item
);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_R  = 8'h72;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CH_LC_V  = 8'h76;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;

  localparam logic [7:0] CTL_BEL = 8'd7;
  localparam logic [7:0] CTL_BS  = 8'd8;
  localparam logic [7:0] CTL_HT  = 8'd9;
  localparam logic [7:0] CTL_LF  = 8'd10;
  localparam logic [7:0] CTL_VT  = 8'd11;
  localparam logic [7:0] CTL_FF  = 8'd12;
  localparam logic [7:0] CTL_CR  = 8'd13;

  localparam int ITEM_W = $bits(esu_pkg::esu_item_t);

  esu_pkg::esu_item_t item;
  logic [ITEM_W-1:0]  q_rdata;
  logic               is_digit;
  logic               is_lc_hex;
  logic               is_uc_hex;

  assign is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign is_lc_hex = (in_byte >= CH_LC_A) && (in_byte <= CH_LC_F);
  assign is_uc_hex = (in_byte >= CH_UC_A) && (in_byte <= CH_UC_F);

  always_comb begin
    item.eos           = in_eos;
    item.cls.ch        = in_byte;
    item.cls.is_hex    = is_digit || is_lc_hex || is_uc_hex;
    // letters a-f and A-F both carry their value minus nine in the low nibble
    item.cls.hex_val   = is_digit ? in_byte[3:0] : 4'(in_byte[3:0] + 4'd9);
    item.cls.is_bslash = (in_byte == esu_pkg::CH_BSLASH);
    item.cls.is_oct    = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
    item.cls.is_x      = (in_byte == CH_LC_X);
    item.cls.is_u      = (in_byte == esu_pkg::CH_LOWER_U);
    item.cls.is_simple = 1'b1;
    unique case (in_byte)
      CH_LC_A: item.cls.simple_val = CTL_BEL;
      CH_LC_B: item.cls.simple_val = CTL_BS;
      CH_LC_F: item.cls.simple_val = CTL_FF;
      CH_LC_N: item.cls.simple_val = CTL_LF;
      CH_LC_R: item.cls.simple_val = CTL_CR;
      CH_LC_T: item.cls.simple_val = CTL_HT;
      CH_LC_V: item.cls.simple_val = CTL_VT;
      default: begin
        item.cls.is_simple  = 1'b0;
        item.cls.simple_val = '0;
      end
    endcase
  end

  esu_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (item),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_item = esu_pkg::esu_item_t'(q_rdata);

endmodule

@@ sv/esu_back.sv @@
// back end: escape decoding state machine, one result per cycle while the result queue has room
`timescale 1ns / 1ps

module esu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  esu_pkg::esu_item_t q_item,
  output logic               q_pop,
  input  logic               res_full,
  output logic               res_push,
  output esu_pkg::esu_res_t  res_data
);

  typedef enum logic [4:0] {
    MODE_PLAIN = 5'b00001,
    MODE_ESC   = 5'b00010,
    MODE_HEX   = 5'b00100,
    MODE_UNI   = 5'b01000,
    MODE_OCT   = 5'b10000
  } mode_t;

  typedef enum logic [2:0] {
    PH_RUN    = 3'b001,
    PH_REPLAY = 3'b010,
    PH_CLOSE  = 3'b100
  } phase_t;

  localparam logic [19:0] HEX_MAX  = 20'd127;
  localparam logic [15:0] ACC_MAX  = 16'd127;
  localparam logic [15:0] CP_2BYTE = 16'h0080;
  localparam logic [15:0] CP_3BYTE = 16'h0800;
  localparam logic [4:0]  SURR_TOP = 5'b11011;

  function automatic esu_pkg::esu_res_t mk_res(logic [7:0] v, logic vld,
                                               esu_pkg::esu_err_t e);
    esu_pkg::esu_res_t r;
    r.value = v;
    r.valid = vld;
    r.last  = 1'b0;
    r.err   = e;
    return r;
  endfunction

  mode_t               mode_r, mode_nxt, mode_s;
  phase_t              phase_r, phase_nxt;
  logic [2:0]          dc_r, dc_nxt, dc_s, dc_dec;
  logic [15:0]         acc_r, acc_nxt, acc_s, uni_acc;
  logic                ovf_r, ovf_nxt, ovf_s;
  logic                stop_r, stop_nxt, stop_s;
  logic [1:0]          k_r, k_nxt;
  logic [1:0]          ridx_r, ridx_nxt;
  logic [1:0]          emit_r, emit_nxt;
  logic                hold_v_r, hold_v_nxt;
  esu_pkg::esu_res_t   hold_r, hold_nxt;
  esu_pkg::esu_class_t held_r [3];

  esu_pkg::esu_class_t src;
  esu_pkg::esu_res_t   r_s [3];
  esu_pkg::esu_res_t   cur;
  esu_pkg::esu_res_t   hex_res;
  logic [1:0]          nres_s;
  logic [19:0]         hex_v;
  logic                held_we;
  logic                do_feed, do_end, do_close;
  logic                active, flushing, step_go, last_emit, commit, close_go;

  // source of the next character: queue head, or a held \u character on replay
  always_comb begin
    if (phase_r == PH_REPLAY) begin
      unique case (ridx_r)
        2'd0:    src = held_r[0];
        2'd1:    src = held_r[1];
        default: src = held_r[2];
      endcase
    end else begin
      src = q_item.cls;
    end
  end

  assign do_feed  = ((phase_r == PH_RUN) && !q_empty && !q_item.eos) ||
                    ((phase_r == PH_REPLAY) && (ridx_r != k_r));
  assign do_end   = ((phase_r == PH_RUN) && !q_empty && q_item.eos) ||
                    ((phase_r == PH_REPLAY) && (ridx_r == k_r));
  assign do_close = (phase_r == PH_CLOSE);

  assign hex_v   = {acc_r, src.hex_val};
  assign uni_acc = (!stop_r && src.is_hex) ? {acc_r[11:0], src.hex_val} : acc_r;
  assign dc_dec  = (dc_r != 3'd0) ? 3'(dc_r - 3'd1) : 3'd0;
  assign hex_res = (!ovf_r && (acc_r != '0) && (acc_r <= ACC_MAX)) ?
                   mk_res(acc_r[7:0], 1'b1, esu_pkg::ERR_OK) :
                   mk_res(8'd0, 1'b1, esu_pkg::ERR_HEX);

  // one decode step: next decoder state and up to three results
  always_comb begin
    mode_s  = mode_r;
    dc_s    = dc_r;
    acc_s   = acc_r;
    ovf_s   = ovf_r;
    stop_s  = stop_r;
    nres_s  = 2'd0;
    held_we = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r_s[i] = mk_res(8'd0, 1'b0, esu_pkg::ERR_OK);
    end
    if (do_end) begin
      mode_s = MODE_PLAIN;
      dc_s   = '0;
      acc_s  = '0;
      ovf_s  = 1'b0;
      stop_s = 1'b0;
      unique case (mode_r)
        MODE_UNI: begin
          nres_s = 2'd2;
          r_s[0] = mk_res(esu_pkg::CH_BSLASH, 1'b1, esu_pkg::ERR_OK);
          r_s[1] = mk_res(esu_pkg::CH_LOWER_U, 1'b1, esu_pkg::ERR_OK);
        end
        MODE_ESC: begin
          nres_s = 2'd1;
          r_s[0] = mk_res(8'd0, 1'b1, esu_pkg::ERR_TRAIL);
        end
        MODE_HEX: begin
          nres_s = 2'd1;
          r_s[0] = hex_res;
        end
        default: nres_s = 2'd0;
      endcase
    end else begin
      unique case (mode_r)
        MODE_HEX: begin
          if (src.is_hex) begin
            if (ovf_r || (hex_v > HEX_MAX)) begin
              ovf_s = 1'b1;
            end else begin
              acc_s = hex_v[15:0];
            end
          end else begin
            // terminator closes the escape; a backslash opens a new one, anything else counts as plain text
            r_s[0] = hex_res;
            acc_s  = '0;
            ovf_s  = 1'b0;
            if (src.is_bslash) begin
              mode_s = MODE_ESC;
              nres_s = 2'd1;
            end else begin
              mode_s = MODE_PLAIN;
              nres_s = 2'd2;
              r_s[1] = mk_res(src.ch, 1'b1, esu_pkg::ERR_OK);
            end
          end
        end
        MODE_ESC: begin
          mode_s = MODE_PLAIN;
          if (src.is_simple) begin
            nres_s = 2'd1;
            r_s[0] = mk_res(src.simple_val, 1'b1, esu_pkg::ERR_OK);
          end else if (src.is_x) begin
            mode_s = MODE_HEX;
            acc_s  = '0;
            ovf_s  = 1'b0;
          end else if (src.is_u) begin
            mode_s = MODE_UNI;
            acc_s  = '0;
            dc_s   = '0;
            stop_s = 1'b0;
          end else if (src.is_oct) begin
            mode_s = MODE_OCT;
            dc_s   = 3'd3;
            nres_s = 2'd1;
            r_s[0] = mk_res(8'd0, 1'b0, esu_pkg::ERR_OCTAL);
          end else begin
            nres_s = 2'd1;
            r_s[0] = mk_res(src.ch, 1'b1, esu_pkg::ERR_OK);
          end
        end
        MODE_UNI: begin
          held_we = (dc_r < 3'd3);
          stop_s  = stop_r || !src.is_hex;
          acc_s   = uni_acc;
          dc_s    = 3'(dc_r + 3'd1);
          if (dc_r == 3'd3) begin
            mode_s = MODE_PLAIN;
            acc_s  = '0;
            dc_s   = '0;
            stop_s = 1'b0;
            if (uni_acc < CP_2BYTE) begin
              nres_s = 2'd1;
              r_s[0] = mk_res(uni_acc[7:0], 1'b1, esu_pkg::ERR_OK);
            end else if (uni_acc < CP_3BYTE) begin
              nres_s = 2'd2;
              r_s[0] = mk_res({3'b110, uni_acc[10:6]}, 1'b1, esu_pkg::ERR_OK);
              r_s[1] = mk_res({2'b10, uni_acc[5:0]}, 1'b1, esu_pkg::ERR_OK);
            end else if (uni_acc[15:11] == SURR_TOP) begin
              nres_s = 2'd1;
              r_s[0] = mk_res(8'd0, 1'b1, esu_pkg::ERR_SURR);
            end else begin
              nres_s = 2'd3;
              r_s[0] = mk_res({4'b1110, uni_acc[15:12]}, 1'b1, esu_pkg::ERR_OK);
              r_s[1] = mk_res({2'b10, uni_acc[11:6]}, 1'b1, esu_pkg::ERR_OK);
              r_s[2] = mk_res({2'b10, uni_acc[5:0]}, 1'b1, esu_pkg::ERR_OK);
            end
          end
        end
        MODE_OCT: begin
          dc_s = dc_dec;
          if (dc_dec == 3'd0) begin
            mode_s = MODE_PLAIN;
          end
        end
        MODE_PLAIN: begin
          if (src.is_bslash) begin
            mode_s = MODE_ESC;
          end else begin
            nres_s = 2'd1;
            r_s[0] = mk_res(src.ch, 1'b1, esu_pkg::ERR_OK);
          end
        end
        default: begin
          mode_s = MODE_PLAIN;
          nres_s = 2'd1;
          r_s[0] = mk_res(src.ch, 1'b1, esu_pkg::ERR_OK);
        end
      endcase
    end
  end

  always_comb begin
    unique case (emit_r)
      2'd0:    cur = r_s[0];
      2'd1:    cur = r_s[1];
      default: cur = r_s[2];
    endcase
  end

  // results of an end marker or of a replay pass through the hold register so that the
  // final one can be tagged as last once the flush is known to be over
  assign active    = do_feed || do_end;
  assign flushing  = (phase_r != PH_RUN) || do_end;
  assign step_go   = active && ((nres_s == 2'd0) || !res_full);
  assign last_emit = (emit_r == 2'(nres_s - 2'd1));
  assign commit    = step_go && ((nres_s == 2'd0) || last_emit);
  assign close_go  = do_close && !res_full;

  assign q_pop = close_go || (commit && do_feed && (phase_r == PH_RUN));

  always_comb begin
    res_push = 1'b0;
    res_data = cur;
    if (do_close) begin
      res_push = !res_full;
      if (hold_v_r) begin
        res_data      = hold_r;
        res_data.last = 1'b1;
      end else begin
        res_data      = mk_res(8'd0, 1'b0, esu_pkg::ERR_OK);
        res_data.last = 1'b1;
      end
    end else if (step_go && (nres_s != 2'd0)) begin
      if (flushing) begin
        res_push = hold_v_r;
        res_data = hold_r;
      end else begin
        res_push = 1'b1;
        res_data = cur;
      end
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    dc_nxt     = dc_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    stop_nxt   = stop_r;
    phase_nxt  = phase_r;
    k_nxt      = k_r;
    ridx_nxt   = ridx_r;
    emit_nxt   = emit_r;
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    if (step_go && (nres_s != 2'd0)) begin
      emit_nxt = commit ? 2'd0 : 2'(emit_r + 2'd1);
      if (flushing) begin
        hold_nxt   = cur;
        hold_v_nxt = 1'b1;
      end
    end
    if (commit) begin
      mode_nxt = mode_s;
      dc_nxt   = dc_s;
      acc_nxt  = acc_s;
      ovf_nxt  = ovf_s;
      stop_nxt = stop_s;
      if (do_end) begin
        if (mode_r == MODE_UNI) begin
          // cut-short \u: replay the characters taken so far
          phase_nxt = PH_REPLAY;
          k_nxt     = dc_r[1:0];
          ridx_nxt  = 2'd0;
        end else begin
          phase_nxt = PH_CLOSE;
        end
      end else if (phase_r == PH_REPLAY) begin
        ridx_nxt = 2'(ridx_r + 2'd1);
      end
    end
    if (close_go) begin
      phase_nxt  = PH_RUN;
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_PLAIN;
      phase_r  <= PH_RUN;
      dc_r     <= '0;
      acc_r    <= '0;
      ovf_r    <= 1'b0;
      stop_r   <= 1'b0;
      k_r      <= '0;
      ridx_r   <= '0;
      emit_r   <= '0;
      hold_v_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      phase_r  <= phase_nxt;
      dc_r     <= dc_nxt;
      acc_r    <= acc_nxt;
      ovf_r    <= ovf_nxt;
      stop_r   <= stop_nxt;
      k_r      <= k_nxt;
      ridx_r   <= ridx_nxt;
      emit_r   <= emit_nxt;
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    for (int i = 0; i < 3; i++) begin
      if (commit && do_feed && held_we && (dc_r[1:0] == 2'(i))) begin
        held_r[i] <= src;
      end
    end
  end

endmodule

@@ sv/escape_sequence_unescaper_core.sv @@
// top level of the escape sequence unescaper
`timescale 1ns / 1ps

// Decodes the body of a C-style string literal, one character per transfer,
// each string closed by an end-marker transfer. Both sides are queues: write
// with push while full is low, read with pop while empty is low. A front end
// classifies characters into a Q_DEPTH-entry queue; the back end decoder
// takes at most one character per cycle and writes one result per cycle into
// an OUT_DEPTH-entry result queue, both while the result queue has room. An
// item that yields zero or one result is a single decoder step, so plain text
// streams at one character per clock while the result queue has room. An item
// yielding n results (a UTF-8 sequence of up to three bytes, or a hex
// terminator plus the character itself) writes them one after another before
// the decoder takes the next character. An end marker is one decoder step that
// writes its results one after another, followed by a closing step that writes
// the final result or the empty end result. A \u cut short by the end adds one
// step per replayed character and one more step to end the replay, again if the replay opens another \u.

module escape_sequence_unescaper_core #(
  parameter int Q_DEPTH   = esu_pkg::Q_DEPTH,
  parameter int OUT_DEPTH = esu_pkg::OUT_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last_of_string,
  output logic [2:0] out_error_code
);

  localparam int RES_W = $bits(esu_pkg::esu_res_t);

  logic               q_pop;
  logic               q_empty;
  esu_pkg::esu_item_t q_item;
  logic               res_push;
  logic               res_full;
  esu_pkg::esu_res_t  res_data;
  logic [RES_W-1:0]   out_rdata;
  esu_pkg::esu_res_t  out_res;

  esu_front #(
    .Q_DEPTH (Q_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_byte (in_byte),
    .in_eos  (in_end_of_string),
    .full    (full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_item  (q_item)
  );

  esu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data)
  );

  esu_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign out_res            = esu_pkg::esu_res_t'(out_rdata);
  assign out_byte           = out_res.value;
  assign out_valid          = out_res.valid;
  assign out_last_of_string = out_res.last;
  assign out_error_code     = out_res.err;

  // the decoder only writes results when the result queue has room
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result written into a full result queue");

  // the decoder only retires a character that is actually queued
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("character queue read while empty");

  // a result without data is either a dropped octal escape or an empty end
  a_invalid_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_valid) |->
      (out_error_code == esu_pkg::ERR_OCTAL) ||
      (out_last_of_string && (out_error_code == esu_pkg::ERR_OK)))
    else $error("result without data of unexpected kind");

  // a shown result stays put until it is read
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_rdata)))
    else $error("waiting result changed before transfer");

endmodule
